FILE: src/rotating_lidar_point_transform_core_defines.svh
// Assertion macros shared by the point transform checker.
`ifndef ROTATING_LIDAR_POINT_TRANSFORM_CORE_DEFINES_SVH
`define ROTATING_LIDAR_POINT_TRANSFORM_CORE_DEFINES_SVH

// Same-cycle implication, masked while aresetn is low.
`define RLPT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rlpt: same-cycle check failed");

// Next-cycle implication, masked while aresetn is low.
`define RLPT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rlpt: next-cycle check failed");

// Next-cycle implication that also runs through reset.
`define RLPT_ASSERT_NEXT_RAW(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("rlpt: reset check failed");

`endif

FILE: src/rlpt_pkg.sv
// Shared types, widths and constants of the lidar point transform.
package rlpt_pkg;

    localparam int COORD_BITS   = 32;
    localparam int ANGLE_BITS   = 16;
    localparam int INTEN_BITS   = 32;

    localparam int ROW_W        = 48;
    localparam int COEF_W       = 16;
    localparam int TRANS_W      = 63;
    localparam int TRANS_PART_W = 21;
    localparam int CFG_DATA_W   = 64;
    localparam int REG_IDX_W    = 3;

    localparam int PROD_W = COORD_BITS + COEF_W;
    localparam int CAL_W  = (COORD_BITS + 4 > TRANS_PART_W + 2) ? COORD_BITS + 4
                                                                : TRANS_PART_W + 2;
    localparam int YAW_W  = COORD_BITS + 17;
    localparam int SAT_W  = (CAL_W > YAW_W) ? CAL_W : YAW_W;

    localparam int FRAC_SHIFT = 14;
    localparam int RND_HALF   = 1 << (FRAC_SHIFT - 1);

    // Quarter-wave sine polynomial, Q16.
    localparam int TRIG_T_W = 17;
    localparam int TRIG_A   = 102944;
    localparam int TRIG_B   = 42048;
    localparam int TRIG_C   = 4640;
    localparam logic [TRIG_T_W-1:0] Q16_ONE = TRIG_T_W'(1 << 16);

    localparam int ANG_RSH = (ANGLE_BITS >= 18) ? ANGLE_BITS - 18 : 0;
    localparam int ANG_LSH = (ANGLE_BITS < 18) ? 18 - ANGLE_BITS : 0;
    localparam logic [ANGLE_BITS-1:0] ANG_QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    localparam logic [COEF_W-1:0] ROT_ONE = COEF_W'(1 << FRAC_SHIFT);

    localparam int NUM_CELLS = 7;

    // Stream word layout.
    localparam int OFS_X      = 0;
    localparam int OFS_Y      = COORD_BITS;
    localparam int OFS_Z      = 2 * COORD_BITS;
    localparam int OFS_ANG    = 3 * COORD_BITS;
    localparam int OFS_INT    = 3 * COORD_BITS + ANGLE_BITS;
    localparam int TDATA_RAW  = 3 * COORD_BITS + ANGLE_BITS + INTEN_BITS;
    localparam int TDATA_W    = ((TDATA_RAW + 7) / 8) * 8;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_ROT_ROW0    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ROT_ROW1    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ROT_ROW2    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TRANSLATION = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ANGLE_OFS   = 3'd4;

    typedef enum logic [2:0] {
        STG_PROD  = 3'd0,
        STG_SUM   = 3'd1,
        STG_SAT   = 3'd2,
        STG_MID   = 3'd3,
        STG_SINE  = 3'd4,
        STG_YMUL  = 3'd5,
        STG_YSUM  = 3'd6
    } stage_t;

    typedef struct packed {
        logic [2:0][ROW_W-1:0]    rot;
        logic [TRANS_W-1:0]       trans;
        logic [ANGLE_BITS-1:0]    offset;
    } cfg_t;

    typedef struct packed {
        logic [2:0][COORD_BITS-1:0] pt;
        logic [ANGLE_BITS-1:0]      ang;
        logic [INTEN_BITS-1:0]      inten;
        logic [1:0][TRIG_T_W:0]     targ;   // {negate, t} for sine and cosine
        logic [8:0][PROD_W-1:0]     prod;
        logic [2:0][CAL_W-1:0]      acc;
        logic [2:0][COORD_BITS-1:0] q;
        logic [1:0][TRIG_T_W-1:0]   t2;
        logic [1:0][15:0]           inner;
        logic [1:0][TRIG_T_W-1:0]   mid;
        logic [1:0][15:0]           sc;     // sine, cosine in Q2.14
        logic [3:0][PROD_W-1:0]     ym;
        logic [2:0][COORD_BITS-1:0] mv;
    } pld_t;

endpackage

FILE: src/rotating_lidar_point_transform_core.sv
// Top level of the rotating lidar point transform: config registers and a row of cells.
//
//   channel  dir  handshake            payload
//   s_       in   s_tvalid / s_tready  s_tdata: point_x, point_y, point_z, turn_angle, intensity
//   m_       out  m_tvalid / m_tready  m_tdata: moved_x, moved_y, moved_z, angle_out,
//                                              intensity_out
//   cfg_     in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// Throughput is one point per clock while the output is not stalled. A beat passes
// through seven cells from input to output: the angle sum and the sine polynomial's four
// dependent multiplies take five cells, the yaw products and the yaw sum the last two;
// calibration products, sums and clipping run alongside in the first three cells.
// Reset (aresetn low, synchronous) empties every cell and loads the identity calibration.
// A stalled output beat holds only the full cells behind it; any empty cell in the row
// still lets an input beat in. Configuration is always accepted.
module rotating_lidar_point_transform_core import rlpt_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Point input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_W-1:0]    s_tdata,   // point_x, point_y, point_z, turn_angle,
                                             // intensity, zero pad (low bit up)
    // Result output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,   // moved_x, moved_y, moved_z, angle_out,
                                             // intensity_out, zero pad (low bit up)
    // Configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [REG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t                 cfg;
    pld_t                 pipe_pld   [NUM_CELLS+1];
    logic [NUM_CELLS:0]   pipe_valid;
    logic [NUM_CELLS:0]   pipe_ready;

    rlpt_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Unpack the input beat into the head of the row.
    always_comb begin
        pipe_pld[0]       = '0;
        pipe_pld[0].pt[0] = s_tdata[OFS_X +: COORD_BITS];
        pipe_pld[0].pt[1] = s_tdata[OFS_Y +: COORD_BITS];
        pipe_pld[0].pt[2] = s_tdata[OFS_Z +: COORD_BITS];
        pipe_pld[0].ang   = s_tdata[OFS_ANG +: ANGLE_BITS];
        pipe_pld[0].inten = s_tdata[OFS_INT +: INTEN_BITS];
    end

    assign pipe_valid[0] = s_tvalid;
    assign s_tready      = pipe_ready[0];

    // Each cell advances its beat to the neighbor when that one can take it.
    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        rlpt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .stage     (stage_t'(3'(i))),
            .cfg       (cfg),
            .in_valid  (pipe_valid[i]),
            .in_ready  (pipe_ready[i]),
            .in_pld    (pipe_pld[i]),
            .out_valid (pipe_valid[i+1]),
            .out_ready (pipe_ready[i+1]),
            .out_pld   (pipe_pld[i+1])
        );
    end

    // The last cell is the output register.
    assign pipe_ready[NUM_CELLS] = m_tready;
    assign m_tvalid = pipe_valid[NUM_CELLS];
    assign m_tdata  = TDATA_W'({pipe_pld[NUM_CELLS].inten,
                                pipe_pld[NUM_CELLS].ang,
                                pipe_pld[NUM_CELLS].mv[2],
                                pipe_pld[NUM_CELLS].mv[1],
                                pipe_pld[NUM_CELLS].mv[0]});

endmodule

FILE: src/rlpt_step.sv
// Datapath of one cell: the work done for the cell's stage code.
module rlpt_step import rlpt_pkg::*; (
    input  stage_t stage,
    input  cfg_t   cfg,
    input  pld_t   pld_in,
    output pld_t   pld_out
);

    function automatic logic [TRIG_T_W:0] trig_arg(input logic [ANGLE_BITS-1:0] a);
        logic [ANGLE_BITS+15:0] w;
        logic [15:0]            u;
        logic [TRIG_T_W-1:0]    t;
        w = (ANGLE_BITS+16)'(a[ANGLE_BITS-3:0]);
        w = (w << ANG_LSH) >> ANG_RSH;
        u = w[15:0];
        t = a[ANGLE_BITS-2] ? Q16_ONE - TRIG_T_W'(u) : TRIG_T_W'(u);
        return {a[ANGLE_BITS-1], t};
    endfunction

    function automatic logic signed [CAL_W-1:0] rnd_prod(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] r;
        r = (p + PROD_W'(RND_HALF)) >>> FRAC_SHIFT;
        return CAL_W'(r);
    endfunction

    function automatic logic [COORD_BITS-1:0] sat_coord(input logic signed [SAT_W-1:0] v);
        logic ovf;
        ovf = !((&v[SAT_W-1:COORD_BITS-1]) || !(|v[SAT_W-1:COORD_BITS-1]));
        return ovf ? {v[SAT_W-1], {(COORD_BITS-1){~v[SAT_W-1]}}} : v[COORD_BITS-1:0];
    endfunction

    function automatic logic [15:0] sine_out(input logic [TRIG_T_W:0] ta,
                                             input logic [TRIG_T_W-1:0] mid);
        logic [33:0] tm;
        logic [17:0] mag;
        logic [15:0] m14;
        tm  = 34'(ta[TRIG_T_W-1:0]) * 34'(mid);
        mag = 18'(tm >> 16);
        m14 = 16'((mag + 18'd2) >> 2);
        return ta[TRIG_T_W] ? 16'd0 - m14 : m14;
    endfunction

    function automatic logic [COORD_BITS-1:0] yaw_out(input logic signed [PROD_W-1:0] a,
                                                      input logic signed [PROD_W-1:0] b,
                                                      input logic sub);
        logic signed [YAW_W-1:0] s;
        s = sub ? YAW_W'(a) - YAW_W'(b) : YAW_W'(a) + YAW_W'(b);
        s = (s + YAW_W'(RND_HALF)) >>> FRAC_SHIFT;
        return sat_coord(SAT_W'(s));
    endfunction

    always_comb begin
        pld_out = pld_in;
        unique case (stage)
            STG_PROD: begin
                for (int r = 0; r < 3; r++) begin
                    for (int k = 0; k < 3; k++) begin
                        pld_out.prod[3*r+k] = PROD_W'($signed(pld_in.pt[k]))
                                            * PROD_W'($signed(cfg.rot[r][COEF_W*k +: COEF_W]));
                    end
                end
                pld_out.targ[0] = trig_arg(ANGLE_BITS'(pld_in.ang + cfg.offset));
                pld_out.targ[1] = trig_arg(ANGLE_BITS'(pld_in.ang + cfg.offset + ANG_QUARTER));
            end
            STG_SUM: begin
                for (int r = 0; r < 3; r++) begin
                    pld_out.acc[r] = CAL_W'($signed(cfg.trans[TRANS_PART_W*r +: TRANS_PART_W]))
                                   + rnd_prod($signed(pld_in.prod[3*r]))
                                   + rnd_prod($signed(pld_in.prod[3*r+1]))
                                   + rnd_prod($signed(pld_in.prod[3*r+2]));
                end
                for (int i = 0; i < 2; i++) begin
                    pld_out.t2[i] = TRIG_T_W'((34'(pld_in.targ[i][TRIG_T_W-1:0])
                                             * 34'(pld_in.targ[i][TRIG_T_W-1:0])) >> 16);
                end
            end
            STG_SAT: begin
                for (int r = 0; r < 3; r++) begin
                    pld_out.q[r] = sat_coord(SAT_W'($signed(pld_in.acc[r])));
                end
                for (int i = 0; i < 2; i++) begin
                    pld_out.inner[i] = 16'(TRIG_B)
                                     - 16'((30'(TRIG_C) * 30'(pld_in.t2[i])) >> 16);
                end
            end
            STG_MID: begin
                for (int i = 0; i < 2; i++) begin
                    pld_out.mid[i] = TRIG_T_W'(TRIG_A)
                                   - TRIG_T_W'((33'(pld_in.t2[i]) * 33'(pld_in.inner[i])) >> 16);
                end
            end
            STG_SINE: begin
                for (int i = 0; i < 2; i++) begin
                    pld_out.sc[i] = sine_out(pld_in.targ[i], pld_in.mid[i]);
                end
            end
            STG_YMUL: begin
                pld_out.ym[0] = PROD_W'($signed(pld_in.sc[1])) * PROD_W'($signed(pld_in.q[0]));
                pld_out.ym[1] = PROD_W'($signed(pld_in.sc[0])) * PROD_W'($signed(pld_in.q[1]));
                pld_out.ym[2] = PROD_W'($signed(pld_in.sc[1])) * PROD_W'($signed(pld_in.q[1]));
                pld_out.ym[3] = PROD_W'($signed(pld_in.sc[0])) * PROD_W'($signed(pld_in.q[0]));
            end
            STG_YSUM: begin
                pld_out.mv[0] = yaw_out($signed(pld_in.ym[0]), $signed(pld_in.ym[1]), 1'b0);
                pld_out.mv[1] = yaw_out($signed(pld_in.ym[2]), $signed(pld_in.ym[3]), 1'b1);
                pld_out.mv[2] = pld_in.q[2];
            end
            default: begin
                pld_out = pld_in;
            end
        endcase
    end

endmodule

FILE: src/rlpt_cell.sv
// One cell of the transform row: stage datapath plus a handshaked holding register.
module rlpt_cell import rlpt_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  stage_t stage,
    input  cfg_t   cfg,
    input  logic   in_valid,
    output logic   in_ready,
    input  pld_t   in_pld,
    output logic   out_valid,
    input  logic   out_ready,
    output pld_t   out_pld
);

    logic valid_reg, valid_next;
    pld_t pld_reg, pld_next;
    pld_t step_pld;

    rlpt_step u_step (
        .stage   (stage),
        .cfg     (cfg),
        .pld_in  (in_pld),
        .pld_out (step_pld)
    );

    // Take a beat when empty or when the held beat leaves this cycle.
    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        pld_next   = pld_reg;
        if (in_ready) begin
            valid_next = in_valid;
            if (in_valid) begin
                pld_next = step_pld;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        pld_reg <= pld_next;
    end

    assign out_valid = valid_reg;
    assign out_pld   = pld_reg;

endmodule

FILE: src/rlpt_cfg_regs.sv
// Calibration and angle offset registers behind the configuration write port.
module rlpt_cfg_regs import rlpt_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [REG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg, cfg_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_ROT_ROW0:    cfg_next.rot[0] = cfg_data[ROW_W-1:0];
                REG_ROT_ROW1:    cfg_next.rot[1] = cfg_data[ROW_W-1:0];
                REG_ROT_ROW2:    cfg_next.rot[2] = cfg_data[ROW_W-1:0];
                REG_TRANSLATION: cfg_next.trans  = cfg_data[TRANS_W-1:0];
                REG_ANGLE_OFS:   cfg_next.offset = cfg_data[ANGLE_BITS-1:0];
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            // Identity rotation, no translation, no offset.
            cfg_reg.rot[0] <= ROW_W'(ROT_ONE);
            cfg_reg.rot[1] <= ROW_W'(ROT_ONE) << COEF_W;
            cfg_reg.rot[2] <= ROW_W'(ROT_ONE) << (2 * COEF_W);
            cfg_reg.trans  <= '0;
            cfg_reg.offset <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: src/rlpt_checker.sv
// Port-level checks of the point transform core, bound onto the top level.
`include "rotating_lidar_point_transform_core_defines.svh"

module rlpt_checker import rlpt_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata
);

    // A refused output beat stays put.
    `RLPT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Input backpressure only comes from a full row behind a stalled output.
    `RLPT_ASSERT_NOW(a_in_stall_cause, !s_tready, m_tvalid && !m_tready)

    // Reset empties the output cell.
    `RLPT_ASSERT_NEXT_RAW(a_reset_empty, !aresetn, !m_tvalid)

endmodule

bind rotating_lidar_point_transform_core rlpt_checker u_rlpt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
